[rtl/rar_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Shared widths and operation codes for the rational arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned OutNumWidth  = 32;
  localparam int unsigned OutDenWidth  = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage

`default_nettype wire

[rtl/rar_gcd_stage.sv]
// ----------------------------------------------------------------------------
// Binary GCD pipeline stage
// One step of the subtract-and-shift binary GCD on a pair of magnitudes,
// registered, with its side data and valid bit carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_gcd_stage #(
  parameter int unsigned MagWidth  = 64,
  parameter int unsigned SideWidth = 8,
  parameter int unsigned ShWidth   = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [MagWidth-1:0]  a_i,
  input  wire logic [MagWidth-1:0]  b_i,
  input  wire logic [ShWidth-1:0]   sh_i,
  input  wire logic [SideWidth-1:0] side_i,
  output logic                      valid_o,
  output logic [MagWidth-1:0]       a_o,
  output logic [MagWidth-1:0]       b_o,
  output logic [ShWidth-1:0]        sh_o,
  output logic [SideWidth-1:0]      side_o
);

  logic [MagWidth-1:0] a_d, b_d, diff;
  logic [ShWidth-1:0]  sh_d;

  // One step: strip common twos, strip lone twos, or subtract the smaller from the larger and halve the difference.
  always_comb begin
    a_d  = a_i;
    b_d  = b_i;
    sh_d = sh_i;
    diff = '0;
    if (a_i != '0 && b_i != '0) begin
      if (!a_i[0] && !b_i[0]) begin
        a_d  = a_i >> 1;
        b_d  = b_i >> 1;
        sh_d = sh_i + ShWidth'(1);
      end else if (!a_i[0]) begin
        a_d = a_i >> 1;
      end else if (!b_i[0]) begin
        b_d = b_i >> 1;
      end else if (a_i >= b_i) begin
        diff = a_i - b_i;
        a_d  = diff >> 1;
      end else begin
        diff = b_i - a_i;
        b_d  = diff >> 1;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o    <= a_d;
      b_o    <= b_d;
      sh_o   <= sh_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

[rtl/rational_arith_reduce.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic with reduction
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the result in lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Usage: an input item (kind and two fractions) is taken on in_valid_i and
// in_ready_o; one result item leaves on out_valid_o and out_ready_i.
// The block is a single pipeline that advances whenever its output register
// is empty or being taken, so one item can enter every cycle.
// The cross products are registered when an item is accepted. Behind them
// come a sign-handling stage, 4*OPERAND_WIDTH binary GCD steps (two per bit
// of the product), a stage that forms the gcd, 2*OPERAND_WIDTH + 1 restoring
// divider stages that divide numerator and denominator by the gcd, and the
// output register.
// Reset empties every stage. When the receiver stalls, the whole pipeline
// holds and in_ready_o falls in the same cycle, so nothing is lost or repeated.
// Division by a zero fraction gives 0/1 with div_zero_o set; a zero result
// is 0/1.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_reduce #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OperandWidth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      kind_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] left_num_i,
  input  wire logic [OPERAND_WIDTH-2:0]        left_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] right_num_i,
  input  wire logic [OPERAND_WIDTH-2:0]        right_den_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [rar_pkg::OutNumWidth-1:0] out_num_o,
  output logic [rar_pkg::OutDenWidth-1:0]      out_den_o,
  output logic                                 div_zero_o
);

  import rar_pkg::*;

  localparam int unsigned W       = OPERAND_WIDTH;
  localparam int unsigned PW      = 2 * W;        // product width (signed)
  localparam int unsigned MW      = 2 * W + 1;    // magnitude of sums
  localparam int unsigned Steps   = 4 * W;
  localparam int unsigned ShW     = $clog2(MW + 1);
  // Side data: neg, zero, divzero, original magnitudes.
  localparam int unsigned SideW   = 3 + 2 * MW;

  typedef struct packed {
    logic          neg;
    logic          zero;
    logic          dz;
    logic [MW-1:0] num;
    logic [MW-1:0] den;
  } side_t;

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: operand decode and four products.
  logic          s1_v_q;
  op_e           s1_op_q;
  logic signed [PW-1:0] s1_p0_q, s1_p1_q, s1_p2_q;
  logic [PW-1:0] s1_p3_q;
  logic          s1_dz_q;

  logic [W-2:0] ld, rd;
  logic signed [PW-1:0] ln_x, rn_x, ld_x, rd_x;
  assign ld   = (left_den_i == '0) ? (W-1)'(1) : left_den_i;
  assign rd   = (right_den_i == '0) ? (W-1)'(1) : right_den_i;
  // Operands extended to the product width so every product is exact.
  assign ln_x = PW'(left_num_i);
  assign rn_x = PW'(right_num_i);
  assign ld_x = PW'(ld);
  assign rd_x = PW'(rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  // Products: a = n1*d2, b = n2*d1, c = n1*n2 (n1*d2 for divide), d = d1*d2.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q <= op_e'(kind_i);
      s1_dz_q <= (op_e'(kind_i) == OP_DIV) && (right_num_i == '0);
      s1_p0_q <= ln_x * rd_x;
      s1_p1_q <= rn_x * ld_x;
      s1_p2_q <= (op_e'(kind_i) == OP_DIV) ? ln_x * rd_x : ln_x * rn_x;
      s1_p3_q <= $unsigned(ld_x * rd_x);
    end
  end

  // Stage 2: form signed numerator and denominator, then magnitudes.
  logic          s2_v_q;
  side_t         s2_side_q;
  logic signed [MW-1:0] n_c, d_c;

  always_comb begin
    unique case (s1_op_q)
      OP_ADD: begin
        n_c = MW'(s1_p0_q) + MW'(s1_p1_q);
        d_c = {1'b0, s1_p3_q};
      end
      OP_SUB: begin
        n_c = MW'(s1_p0_q) - MW'(s1_p1_q);
        d_c = {1'b0, s1_p3_q};
      end
      OP_MUL: begin
        n_c = MW'(s1_p2_q);
        d_c = {1'b0, s1_p3_q};
      end
      default: begin
        // Divide: n = n1*d2, d = d1*n2, sign moved to numerator.
        if (s1_p1_q < 0) begin
          n_c = -MW'(s1_p2_q);
          d_c = -MW'(s1_p1_q);
        end else begin
          n_c = MW'(s1_p2_q);
          d_c = MW'(s1_p1_q);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q.neg  <= n_c[MW-1];
      s2_side_q.zero <= (n_c == '0) || s1_dz_q;
      s2_side_q.dz   <= s1_dz_q;
      s2_side_q.num  <= n_c[MW-1] ? MW'(-n_c) : MW'(n_c);
      s2_side_q.den  <= MW'(d_c);
    end
  end

  // GCD chain: Steps registered stages.
  logic [MW-1:0]   ga   [Steps+1];
  logic [MW-1:0]   gb   [Steps+1];
  logic [ShW-1:0]  gsh  [Steps+1];
  logic [SideW-1:0] gsd [Steps+1];
  logic            gv   [Steps+1];

  assign ga[0]  = s2_side_q.zero ? MW'(1) : s2_side_q.num;
  assign gb[0]  = s2_side_q.zero ? MW'(1) : s2_side_q.den;
  assign gsh[0] = '0;
  assign gsd[0] = s2_side_q;
  assign gv[0]  = s2_v_q;

  for (genvar k = 0; k < Steps; k++) begin : g_gcd
    rar_gcd_stage #(
      .MagWidth (MW),
      .SideWidth(SideW),
      .ShWidth  (ShW)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(gv[k]),
      .a_i    (ga[k]),
      .b_i    (gb[k]),
      .sh_i   (gsh[k]),
      .side_i (gsd[k]),
      .valid_o(gv[k+1]),
      .a_o    (ga[k+1]),
      .b_o    (gb[k+1]),
      .sh_o   (gsh[k+1]),
      .side_o (gsd[k+1])
    );
  end

  // Final gcd = (nonzero one of a, b) << sh.
  side_t          fin_side;
  logic [MW-1:0]  g_odd;
  assign fin_side = side_t'(gsd[Steps]);
  assign g_odd    = (ga[Steps] != '0) ? ga[Steps] : gb[Steps];

  // Stage G: register the gcd.
  logic           sg_v_q;
  side_t          sg_side_q;
  logic [MW-1:0]  sg_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_v_q <= 1'b0;
    end else if (adv) begin
      sg_v_q <= gv[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sg_side_q <= fin_side;
      sg_g_q    <= g_odd << gsh[Steps];
    end
  end

  // Exact division by the gcd: restoring divider pipelined one bit per stage.
  // Both quotients are computed side by side.
  logic [MW-1:0] qn [MW+1];
  logic [MW-1:0] qd [MW+1];
  logic [MW-1:0] rn [MW+1];
  logic [MW-1:0] rdm[MW+1];
  logic [MW-1:0] dv [MW+1];
  side_t         dsd[MW+1];
  logic          dvv[MW+1];

  assign qn[0]  = sg_side_q.num;
  assign qd[0]  = sg_side_q.den;
  assign rn[0]  = '0;
  assign rdm[0] = '0;
  assign dv[0]  = sg_g_q;
  assign dsd[0] = sg_side_q;
  assign dvv[0] = sg_v_q;

  for (genvar k = 0; k < MW; k++) begin : g_div
    logic [MW:0]   tn, td;
    logic [MW-1:0] qn_q, qd_q, rn_q, rd_q, dv_q;
    side_t         sd_q;
    logic          v_q;
    assign tn = {rn[k], qn[k][MW-1]};
    assign td = {rdm[k], qd[k][MW-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (adv) begin
        v_q <= dvv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (tn >= {1'b0, dv[k]}) begin
          rn_q <= MW'(tn - {1'b0, dv[k]});
          qn_q <= {qn[k][MW-2:0], 1'b1};
        end else begin
          rn_q <= MW'(tn);
          qn_q <= {qn[k][MW-2:0], 1'b0};
        end
        if (td >= {1'b0, dv[k]}) begin
          rd_q <= MW'(td - {1'b0, dv[k]});
          qd_q <= {qd[k][MW-2:0], 1'b1};
        end else begin
          rd_q <= MW'(td);
          qd_q <= {qd[k][MW-2:0], 1'b0};
        end
        dv_q <= dv[k];
        sd_q <= dsd[k];
      end
    end

    assign qn[k+1]  = qn_q;
    assign qd[k+1]  = qd_q;
    assign rn[k+1]  = rn_q;
    assign rdm[k+1] = rd_q;
    assign dv[k+1]  = dv_q;
    assign dsd[k+1] = sd_q;
    assign dvv[k+1] = v_q;
  end

  // Output register.
  side_t         os;
  logic [MW-1:0] onum;
  assign os   = dsd[MW];
  assign onum = os.neg ? MW'(-qn[MW]) : qn[MW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= dvv[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_zero_o <= os.dz;
      if (os.zero) begin
        out_num_o <= '0;
        out_den_o <= OutDenWidth'(1);
      end else begin
        // Sign-extended for narrow operands, low bits kept for wide ones.
        out_num_o <= OutNumWidth'(signed'(onum));
        out_den_o <= OutDenWidth'(qd[MW]);
      end
    end
  end

  logic unused;
  assign unused = ^{rn[MW], rdm[MW], dv[MW]};

endmodule

`default_nettype wire

[rtl/rar_checker.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic port checker
// Watches the top-level ports for handshake and result sanity.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_checker #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OperandWidth
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_num_o,
  input wire logic [30:0] out_den_o,
  input wire logic        div_zero_o
);

  // A result held back keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_num_o))
    else $error("result changed while stalled");

  // The input side stalls exactly when a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // A divide fault reports 0/1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> out_num_o == '0 && out_den_o == 31'd1)
    else $error("divide fault without 0/1");

  // A zero numerator always comes with denominator one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_num_o == '0 |-> out_den_o == 31'd1)
    else $error("zero result not 0/1");

endmodule

bind rational_arith_reduce rar_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_rar_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_num_o  (out_num_o),
  .out_den_o  (out_den_o),
  .div_zero_o (div_zero_o)
);

`default_nettype wire
